// ===== rtl/rie_pkg.sv =====
// Package for the SimpleRISC instruction executor: opcodes, sizes and reset constants.
// It depends on nothing else.
`timescale 1ns / 1ps
package rie_pkg;
    localparam int DMEM_WORDS_DEF = 1024;
    localparam int REG_COUNT_DEF  = 16;
    localparam logic [31:0] SP_RESET = 32'd3000;
    localparam logic [3:0] SP_REG = 4'd14;
    localparam logic [3:0] RA_REG = 4'd15;

    typedef enum logic [4:0] {
        OP_ADD = 5'd0, OP_SUB = 5'd1, OP_MUL = 5'd2, OP_DIV = 5'd3, OP_MOD = 5'd4,
        OP_CMP = 5'd5, OP_AND = 5'd6, OP_OR = 5'd7, OP_NOT = 5'd8, OP_MOV = 5'd9,
        OP_LSL = 5'd10, OP_LSR = 5'd11, OP_ASR = 5'd12, OP_NOP = 5'd13,
        OP_LD = 5'd14, OP_ST = 5'd15, OP_BEQ = 5'd16, OP_BGT = 5'd17, OP_B = 5'd18,
        OP_CALL = 5'd19, OP_RET = 5'd20
    } t_op;

    typedef enum logic [1:0] {
        MOD_DEF = 2'd0, MOD_U = 2'd1, MOD_H = 2'd2, MOD_X = 2'd3
    } t_mod;

    typedef struct packed {
        logic        start;
        logic [31:0] a;
        logic [31:0] b;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
        logic [31:0] rem;
    } t_div_rsp;
endpackage

// ===== rtl/rie_divider.sv =====
// Iterative signed divider for div and mod, one quotient bit per cycle.
// It depends on rie_pkg for the request and response structs.
`timescale 1ns / 1ps
module rie_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rie_pkg::t_div_req i_req,
    output rie_pkg::t_div_rsp o_rsp
);
    logic        r_busy;
    logic [5:0]  r_cnt;
    logic [31:0] r_quo;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic        r_nq;
    logic        r_nr;
    logic        r_done;
    logic [32:0] w_shift;
    logic [32:0] w_diff;
    logic [31:0] w_ua;
    logic [31:0] w_ub;

    assign w_ua = i_req.a[31] ? (32'd0 - i_req.a) : i_req.a;
    assign w_ub = i_req.b[31] ? (32'd0 - i_req.b) : i_req.b;
    assign w_shift = {r_rem[31:0], r_quo[31]};
    assign w_diff = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt <= 6'd32;
                r_quo <= w_ua;
                r_rem <= '0;
                r_den <= w_ub;
                r_nq <= i_req.a[31] ^ i_req.b[31];
                r_nr <= i_req.a[31];
            end else if (r_busy) begin
                if (!w_diff[32]) begin
                    r_rem <= w_diff;
                    r_quo <= {r_quo[30:0], 1'b1};
                end else begin
                    r_rem <= w_shift;
                    r_quo <= {r_quo[30:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo = r_nq ? (32'd0 - r_quo) : r_quo;
    assign o_rsp.rem = r_nr ? (32'd0 - r_rem[31:0]) : r_rem[31:0];
endmodule

// ===== rtl/risc_instruction_executor_core.sv =====
// Top level of the SimpleRISC instruction executor: sequencer, register file, flags,
// shared ALU and data memory. It depends on rie_pkg and rie_divider.
//
//   channel | valid   | stall   | payload
//   in      | i_valid | o_stall | i_operation, i_instruction, i_load_address, i_load_data
//   out     | o_valid | i_stall | o_fetch_pc, o_wb_valid, o_wb_reg, o_wb_value, flags, status
//
// After reset a clearing pass writes zero to every data memory word.
// An ALU instruction goes through accept, register read, execute in the shared ALU and write back.
// Loads and stores add a memory step; div and mod by a nonzero divisor wait in a divide state for the divider.
// A preload, a zero word or an instruction after a halt skips execute: accept, register read, write back.
// The result sits in an output register; a new item is taken only while idle and once that register is free.
`timescale 1ns / 1ps
module risc_instruction_executor_core #(
    parameter int DMEM_WORDS = rie_pkg::DMEM_WORDS_DEF,
    parameter int REG_COUNT  = rie_pkg::REG_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_operation,
    input  logic [31:0] i_instruction,
    input  logic [9:0]  i_load_address,
    input  logic [31:0] i_load_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_fetch_pc,
    output logic        o_wb_valid,
    output logic [3:0]  o_wb_reg,
    output logic [31:0] o_wb_value,
    output logic        o_flag_eq,
    output logic        o_flag_gt,
    output logic        o_mem_fault,
    output logic        o_halted
);
    localparam int AW = $clog2(DMEM_WORDS);
    localparam int RW = $clog2(REG_COUNT);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_EXEC, S_DIV, S_MEM, S_WB
    } t_state;

    t_state      r_state;
    logic [AW:0] r_clr;
    logic [31:0] r_regs [REG_COUNT];
    logic [31:0] r_dmem [DMEM_WORDS];
    logic [31:0] r_pc;
    logic        r_eq;
    logic        r_gt;
    logic        r_stop;
    logic        r_op;
    logic [31:0] r_ins;
    logic [9:0]  r_laddr;
    logic [31:0] r_ldata;
    logic [31:0] r_a;
    logic [31:0] r_b;
    logic [31:0] r_st;
    logic [31:0] r_res;
    logic [31:0] r_npc;
    logic        r_wb;
    logic [3:0]  r_rd;
    logic        r_fault;
    logic [31:0] r_rdata;
    logic        r_out_v;
    logic [31:0] r_o_pc;
    logic        r_o_wb;
    logic [3:0]  r_o_rd;
    logic [31:0] r_o_val;
    logic        r_o_eq;
    logic        r_o_gt;
    logic        r_o_fault;
    logic        r_o_halt;

    rie_pkg::t_div_req w_dreq;
    rie_pkg::t_div_rsp w_drsp;
    rie_pkg::t_op      w_op;
    logic [31:0] w_imm;
    logic [31:0] w_off;
    logic [31:0] w_alu;
    logic [31:0] w_addr;
    logic [4:0]  w_sh;
    logic        w_accept;
    logic        w_oadv;
    logic        w_oob;

    assign w_op = rie_pkg::t_op'(r_ins[31:27]);
    assign w_sh = r_b[4:0];
    assign w_oadv = r_out_v && !i_stall;
    assign o_stall = (r_state != S_IDLE) || (r_out_v && i_stall);
    assign w_accept = i_valid && !o_stall;
    assign w_off = {{3{r_ins[26]}}, r_ins[26:0], 2'b00};
    assign w_addr = r_a + w_imm;
    assign w_oob = (w_addr[31:2] >= 30'(DMEM_WORDS));

    always_comb begin
        case (rie_pkg::t_mod'(r_ins[17:16]))
            rie_pkg::MOD_U: w_imm = {16'd0, r_ins[15:0]};
            rie_pkg::MOD_H: w_imm = {r_ins[15:0], 16'd0};
            default:        w_imm = {{16{r_ins[15]}}, r_ins[15:0]};
        endcase
    end

    always_comb begin
        case (w_op)
            rie_pkg::OP_ADD: w_alu = r_a + r_b;
            rie_pkg::OP_SUB: w_alu = r_a - r_b;
            rie_pkg::OP_MUL: w_alu = r_a * r_b;
            rie_pkg::OP_AND: w_alu = r_a & r_b;
            rie_pkg::OP_OR:  w_alu = r_a | r_b;
            rie_pkg::OP_NOT: w_alu = ~r_b;
            rie_pkg::OP_MOV: w_alu = r_b;
            rie_pkg::OP_LSL: w_alu = r_a << w_sh;
            rie_pkg::OP_LSR: w_alu = r_a >> w_sh;
            rie_pkg::OP_ASR: w_alu = 32'($signed(r_a) >>> w_sh);
            rie_pkg::OP_CALL: w_alu = r_pc + 32'd4;
            default: w_alu = '0;
        endcase
    end

    assign w_dreq.start = (r_state == S_EXEC) && (r_b != 32'd0) &&
        ((w_op == rie_pkg::OP_DIV) || (w_op == rie_pkg::OP_MOD));
    assign w_dreq.a = r_a;
    assign w_dreq.b = r_b;

    rie_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_dreq),
        .o_rsp  (w_drsp)
    );

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            r_dmem[r_clr[AW-1:0]] <= '0;
        end else if (r_state == S_READ && r_op && (32'(r_laddr) < 32'(DMEM_WORDS))) begin
            r_dmem[AW'(r_laddr)] <= r_ldata;
        end else if (r_state == S_MEM && w_op == rie_pkg::OP_ST && !r_fault) begin
            r_dmem[w_addr[AW+1:2]] <= r_st;
        end
        r_rdata <= r_dmem[w_addr[AW+1:2]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_pc <= '0;
            r_eq <= 1'b0;
            r_gt <= 1'b0;
            r_stop <= 1'b0;
            r_out_v <= 1'b0;
            for (int k = 0; k < REG_COUNT; k++) begin
                r_regs[k] <= (RW'(k) == RW'(rie_pkg::SP_REG)) ? rie_pkg::SP_RESET : '0;
            end
        end else begin
            if (w_oadv) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (AW+1)'(DMEM_WORDS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_op <= i_operation;
                        r_ins <= i_instruction;
                        r_laddr <= i_load_address;
                        r_ldata <= i_load_data;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_a <= r_regs[r_ins[21:18]];
                    r_b <= r_ins[26] ? w_imm : r_regs[r_ins[17:14]];
                    r_st <= r_regs[r_ins[25:22]];
                    r_rd <= r_ins[25:22];
                    r_wb <= 1'b0;
                    r_fault <= 1'b0;
                    r_npc <= r_pc;
                    if (r_op || r_stop || r_ins == 32'd0) begin
                        if (!r_op && r_ins == 32'd0) begin
                            r_stop <= 1'b1;
                        end
                        r_state <= S_WB;
                    end else begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_res <= w_alu;
                    r_npc <= r_pc + 32'd4;
                    r_state <= S_WB;
                    case (w_op)
                        rie_pkg::OP_ADD, rie_pkg::OP_SUB, rie_pkg::OP_MUL, rie_pkg::OP_AND,
                        rie_pkg::OP_OR, rie_pkg::OP_NOT, rie_pkg::OP_MOV, rie_pkg::OP_LSL,
                        rie_pkg::OP_LSR, rie_pkg::OP_ASR: r_wb <= 1'b1;
                        rie_pkg::OP_DIV, rie_pkg::OP_MOD: begin
                            r_wb <= 1'b1;
                            if (r_b == 32'd0) begin
                                r_res <= (w_op == rie_pkg::OP_DIV) ? '1 : r_a;
                            end else begin
                                r_state <= S_DIV;
                            end
                        end
                        rie_pkg::OP_CMP: begin
                            r_eq <= (r_a == r_b);
                            r_gt <= ($signed(r_a) > $signed(r_b));
                        end
                        rie_pkg::OP_LD, rie_pkg::OP_ST: begin
                            if (w_oob) begin
                                r_fault <= 1'b1;
                                r_stop <= 1'b1;
                                r_npc <= r_pc;
                            end
                            r_state <= S_MEM;
                        end
                        rie_pkg::OP_BEQ: if (r_eq) r_npc <= r_pc + w_off;
                        rie_pkg::OP_BGT: if (r_gt) r_npc <= r_pc + w_off;
                        rie_pkg::OP_B: r_npc <= r_pc + w_off;
                        rie_pkg::OP_CALL: begin
                            r_wb <= 1'b1;
                            r_rd <= rie_pkg::RA_REG;
                            r_npc <= r_pc + w_off;
                        end
                        rie_pkg::OP_RET: r_npc <= r_regs[rie_pkg::RA_REG];
                        default: ;
                    endcase
                end
                S_DIV: begin
                    if (w_drsp.done) begin
                        r_res <= (w_op == rie_pkg::OP_DIV) ? w_drsp.quo : w_drsp.rem;
                        r_state <= S_WB;
                    end
                end
                S_MEM: begin
                    r_state <= S_WB;
                end
                S_WB: begin
                    if (!r_out_v || w_oadv) begin
                        logic [31:0] v_val;
                        v_val = (w_op == rie_pkg::OP_LD) ? r_rdata : r_res;
                        if (r_wb || (w_op == rie_pkg::OP_LD && !r_fault && !r_op
                                && r_state == S_WB && !r_stop)) begin
                            r_regs[r_rd] <= v_val;
                        end
                        r_o_wb <= r_wb || (w_op == rie_pkg::OP_LD && !r_fault && !r_op && !r_stop);
                        r_o_rd <= (r_wb || (w_op == rie_pkg::OP_LD && !r_fault && !r_op
                                && !r_stop)) ? r_rd : 4'd0;
                        r_o_val <= (r_wb || (w_op == rie_pkg::OP_LD && !r_fault && !r_op
                                && !r_stop)) ? v_val : 32'd0;
                        r_pc <= r_npc;
                        r_o_pc <= r_npc;
                        r_o_eq <= r_eq;
                        r_o_gt <= r_gt;
                        r_o_fault <= r_fault;
                        r_o_halt <= r_stop;
                        r_out_v <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_out_v;
    assign o_fetch_pc = r_o_pc;
    assign o_wb_valid = r_o_wb;
    assign o_wb_reg = r_o_rd;
    assign o_wb_value = r_o_val;
    assign o_flag_eq = r_o_eq;
    assign o_flag_gt = r_o_gt;
    assign o_mem_fault = r_o_fault;
    assign o_halted = r_o_halt;

    a_fault_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_mem_fault) |-> o_halted) else $error("fault without halt");
    a_no_wb_on_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_mem_fault) |-> !o_wb_valid) else $error("write back on fault");
    a_stall_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall) else $error("ready while busy");
    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_stop) && $past(i_rst_n) |-> r_stop) else $error("halt cleared");
endmodule
